@@ src/nonpreemptive_priority_scheduler_top_macros.svh @@
// Assertion macros for the priority scheduler block.
// Included by the top level; no other dependencies.
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// a implies b in the same cycle
`define NPS_ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("implication check failed");
// cond never holds
`define NPS_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define NPS_ASSERT_IMPL(label, clk, rst_n, a, b)
`define NPS_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ src/nps_pkg.sv @@
// Shared constants and types for the priority scheduler.
// No dependencies.
`default_nettype none
package nps_pkg;
  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int ARR_W     = 16;
  localparam int BURST_W   = 16;
  localparam int PRI_W     = 8;
  localparam int TIME_W    = 23;
  localparam int SUM_W     = 30;
  localparam int PNUM_W    = 7;

  // One process table entry as seen at the read port
  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRI_W-1:0]   priority_level;
    logic               finished;
    logic [TIME_W-1:0]  run_start;
    logic [TIME_W-1:0]  finish_time;
  } entry_t;

  // Compare unit verdict for one scanned entry
  typedef struct packed {
    logic take;      // entry becomes the new best ready pick
    logic earliest;  // entry has the earliest unfinished arrival so far
  } cmp_res_t;
endpackage
`default_nettype wire

@@ src/nps_store.sv @@
// Process table: arrival, burst, priority, start and finish per entry,
// plus finished flags. Uses nps_pkg.
`default_nettype none
module nps_store (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        load_en,
  input  wire logic [nps_pkg::IDX_W-1:0]   load_idx,
  input  wire logic [nps_pkg::ARR_W-1:0]   load_arrival,
  input  wire logic [nps_pkg::BURST_W-1:0] load_burst,
  input  wire logic [nps_pkg::PRI_W-1:0]   load_priority,
  input  wire logic                        sched_wr,
  input  wire logic [nps_pkg::IDX_W-1:0]   sched_idx,
  input  wire logic [nps_pkg::TIME_W-1:0]  sched_start,
  input  wire logic [nps_pkg::TIME_W-1:0]  sched_finish,
  input  wire logic                        clr_finished,
  input  wire logic [nps_pkg::IDX_W-1:0]   rd_idx,
  output nps_pkg::entry_t                  rd_entry
);
  logic [nps_pkg::ARR_W-1:0]   arrival_r  [nps_pkg::MAX_PROCS];
  logic [nps_pkg::BURST_W-1:0] burst_r    [nps_pkg::MAX_PROCS];
  logic [nps_pkg::PRI_W-1:0]   priority_r [nps_pkg::MAX_PROCS];
  logic [nps_pkg::TIME_W-1:0]  start_r    [nps_pkg::MAX_PROCS];
  logic [nps_pkg::TIME_W-1:0]  finish_r   [nps_pkg::MAX_PROCS];
  logic [nps_pkg::MAX_PROCS-1:0] finished_r;

  // record load
  always_ff @(posedge clk) begin
    if (load_en) begin
      arrival_r[load_idx]  <= load_arrival;
      burst_r[load_idx]    <= load_burst;
      priority_r[load_idx] <= load_priority;
    end
  end

  // schedule results
  always_ff @(posedge clk) begin
    if (sched_wr) begin
      start_r[sched_idx]  <= sched_start;
      finish_r[sched_idx] <= sched_finish;
    end
  end

  // finished flags, cleared at reset and at the end of a run
  always_ff @(posedge clk) begin
    if (!rst_n || clr_finished) begin
      finished_r <= '0;
    end else if (sched_wr) begin
      finished_r[sched_idx] <= 1'b1;
    end
  end

  // single read port
  always_comb begin
    rd_entry.arrival        = arrival_r[rd_idx];
    rd_entry.burst          = burst_r[rd_idx];
    rd_entry.priority_level = priority_r[rd_idx];
    rd_entry.finished       = finished_r[rd_idx];
    rd_entry.run_start      = start_r[rd_idx];
    rd_entry.finish_time    = finish_r[rd_idx];
  end
endmodule
`default_nettype wire

@@ src/nps_cmp.sv @@
// Shared compare unit: judges one scanned entry against the running best
// pick and the running earliest arrival. Uses nps_pkg.
`default_nettype none
module nps_cmp (
  input  wire nps_pkg::entry_t            entry,
  input  wire logic [nps_pkg::TIME_W-1:0] sched_clock,
  input  wire logic                       have_best,
  input  wire logic [nps_pkg::PRI_W-1:0]  best_priority,
  input  wire logic [nps_pkg::ARR_W-1:0]  best_arrival,
  input  wire logic                       have_next,
  input  wire logic [nps_pkg::ARR_W-1:0]  next_arrival,
  output nps_pkg::cmp_res_t               res
);
  logic ready;
  logic better;

  always_comb begin
    // arrived and still waiting
    ready  = !entry.finished &&
             ({{(nps_pkg::TIME_W-nps_pkg::ARR_W){1'b0}}, entry.arrival} <= sched_clock);
    // scan runs in ascending number, so an exact tie keeps the old best
    better = (entry.priority_level < best_priority) ||
             ((entry.priority_level == best_priority) && (entry.arrival < best_arrival));
    res.take     = ready && (!have_best || better);
    res.earliest = !entry.finished && (!have_next || (entry.arrival < next_arrival));
  end
endmodule
`default_nettype wire

@@ src/nonpreemptive_priority_scheduler_top.sv @@
// Top level of the non-preemptive priority scheduler: sequencer, clock and
// sums. Uses nps_pkg, nps_store, nps_cmp and the assertion macro header.
// Usage:
//   Input: drive a process record on in_* and raise start; it transfers at a
//   clock edge with start high and busy low. Records are numbered 1.. in
//   entry order; in_last_process closes the set. Records beyond 16 stored are
//   dropped, but a last mark on such a record still starts the run.
//   A record without the last mark leaves busy low.
//   Schedule: each decision scans all n stored entries, one per cycle, through
//   the single compare unit, then, in the DECIDE state, commits the pick or
//   jumps the clock to the next arrival. A run makes n decisions plus one per
//   idle gap, then issues n results in the EMIT state.
//   Output: one result per process in number order, each on out_* for one
//   cycle with out_strobe high; out_last_result marks the final one, whose
//   out_total_* carry the full sums. The receiver cannot stall.
//   busy stays high from the last-marked record until the last result has
//   been issued; a new set may be started while that result is shown.
//   Reset (rst_n low, synchronous) empties the table and zeroes the clock and
//   sums; the same happens after every run.
`default_nettype none
`include "nonpreemptive_priority_scheduler_top_macros.svh"
module nonpreemptive_priority_scheduler_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [nps_pkg::ARR_W-1:0]   in_arrival_time,
  input  wire logic [nps_pkg::BURST_W-1:0] in_burst_time,
  input  wire logic [nps_pkg::PRI_W-1:0]   in_priority_level,
  input  wire logic                        in_last_process,
  output logic                             out_strobe,
  output logic [nps_pkg::PNUM_W-1:0]       out_process_number,
  output logic [nps_pkg::TIME_W-1:0]       out_start_time,
  output logic [nps_pkg::TIME_W-1:0]       out_finish_time,
  output logic [nps_pkg::TIME_W-1:0]       out_wait_time,
  output logic [nps_pkg::TIME_W-1:0]       out_turnaround,
  output logic [nps_pkg::SUM_W-1:0]        out_total_wait,
  output logic [nps_pkg::SUM_W-1:0]        out_total_turnaround,
  output logic                             out_last_result
);
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic [nps_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [nps_pkg::CNT_W-1:0]     done_r, done_nxt;
  logic [nps_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic [nps_pkg::TIME_W-1:0]    clock_r, clock_nxt;
  logic [nps_pkg::SUM_W-1:0]     wsum_r, wsum_nxt;
  logic [nps_pkg::SUM_W-1:0]     tsum_r, tsum_nxt;
  logic                          have_r, have_nxt;
  logic                          any_r, any_nxt;
  logic [nps_pkg::IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [nps_pkg::PRI_W-1:0]     best_pri_r, best_pri_nxt;
  logic [nps_pkg::ARR_W-1:0]     best_arr_r, best_arr_nxt;
  logic [nps_pkg::BURST_W-1:0]   best_burst_r, best_burst_nxt;
  logic [nps_pkg::ARR_W-1:0]     next_arr_r, next_arr_nxt;

  logic                          strobe_r, strobe_nxt;
  logic [nps_pkg::PNUM_W-1:0]    pnum_r;
  logic [nps_pkg::TIME_W-1:0]    start_t_r, finish_t_r, wait_t_r, turn_t_r;
  logic [nps_pkg::SUM_W-1:0]     owsum_r, otsum_r;
  logic                          olast_r;

  nps_pkg::entry_t               ent;
  nps_pkg::cmp_res_t             cres;
  logic                          accept;
  logic                          load_en;
  logic                          sched_wr;
  logic                          clr_fin;
  logic                          idx_at_end;
  logic [nps_pkg::TIME_W-1:0]    finish_calc;
  logic [nps_pkg::TIME_W-1:0]    turn_calc;
  logic [nps_pkg::TIME_W-1:0]    wait_calc;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign load_en = accept && (count_r < nps_pkg::CNT_W'(nps_pkg::MAX_PROCS));

  nps_store u_store (
    .clk           (clk),
    .rst_n         (rst_n),
    .load_en       (load_en),
    .load_idx      (count_r[nps_pkg::IDX_W-1:0]),
    .load_arrival  (in_arrival_time),
    .load_burst    (in_burst_time),
    .load_priority (in_priority_level),
    .sched_wr      (sched_wr),
    .sched_idx     (best_idx_r),
    .sched_start   (clock_r),
    .sched_finish  (finish_calc),
    .clr_finished  (clr_fin),
    .rd_idx        (idx_r),
    .rd_entry      (ent)
  );

  nps_cmp u_cmp (
    .entry         (ent),
    .sched_clock   (clock_r),
    .have_best     (have_r),
    .best_priority (best_pri_r),
    .best_arrival  (best_arr_r),
    .have_next     (any_r),
    .next_arrival  (next_arr_r),
    .res           (cres)
  );

  // time arithmetic
  assign finish_calc = clock_r + nps_pkg::TIME_W'(best_burst_r);
  assign turn_calc   = ent.finish_time - nps_pkg::TIME_W'(ent.arrival);
  assign wait_calc   = turn_calc - nps_pkg::TIME_W'(ent.burst);
  assign idx_at_end  = (nps_pkg::CNT_W'(idx_r) + 1'b1) == count_r;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    done_nxt       = done_r;
    idx_nxt        = idx_r;
    clock_nxt      = clock_r;
    wsum_nxt       = wsum_r;
    tsum_nxt       = tsum_r;
    have_nxt       = have_r;
    any_nxt        = any_r;
    best_idx_nxt   = best_idx_r;
    best_pri_nxt   = best_pri_r;
    best_arr_nxt   = best_arr_r;
    best_burst_nxt = best_burst_r;
    next_arr_nxt   = next_arr_r;
    strobe_nxt     = 1'b0;
    sched_wr       = 1'b0;
    clr_fin        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (load_en) begin
            count_nxt = count_r + 1'b1;
          end
          if (in_last_process) begin
            state_nxt = ST_SCAN;
            idx_nxt   = '0;
            have_nxt  = 1'b0;
            any_nxt   = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (cres.take) begin
          have_nxt       = 1'b1;
          best_idx_nxt   = idx_r;
          best_pri_nxt   = ent.priority_level;
          best_arr_nxt   = ent.arrival;
          best_burst_nxt = ent.burst;
        end
        if (cres.earliest) begin
          any_nxt      = 1'b1;
          next_arr_nxt = ent.arrival;
        end
        if (idx_at_end) begin
          state_nxt = ST_DECIDE;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DECIDE: begin
        have_nxt = 1'b0;
        any_nxt  = 1'b0;
        if (have_r) begin
          // commit the pick and run it to completion
          sched_wr  = 1'b1;
          clock_nxt = finish_calc;
          done_nxt  = done_r + 1'b1;
          state_nxt = ((done_r + 1'b1) == count_r) ? ST_EMIT : ST_SCAN;
        end else begin
          // nothing ready: jump to the next arrival
          clock_nxt = nps_pkg::TIME_W'(next_arr_r);
          state_nxt = ST_SCAN;
        end
      end
      ST_EMIT: begin
        strobe_nxt = 1'b1;
        wsum_nxt   = wsum_r + nps_pkg::SUM_W'(wait_calc);
        tsum_nxt   = tsum_r + nps_pkg::SUM_W'(turn_calc);
        if (idx_at_end) begin
          // run over: back to the empty table
          state_nxt = ST_IDLE;
          count_nxt = '0;
          done_nxt  = '0;
          idx_nxt   = '0;
          clock_nxt = '0;
          wsum_nxt  = '0;
          tsum_nxt  = '0;
          clr_fin   = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      done_r   <= '0;
      idx_r    <= '0;
      clock_r  <= '0;
      wsum_r   <= '0;
      tsum_r   <= '0;
      have_r   <= 1'b0;
      any_r    <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      done_r   <= done_nxt;
      idx_r    <= idx_nxt;
      clock_r  <= clock_nxt;
      wsum_r   <= wsum_nxt;
      tsum_r   <= tsum_nxt;
      have_r   <= have_nxt;
      any_r    <= any_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // best pick and earliest arrival registers
  always_ff @(posedge clk) begin
    best_idx_r   <= best_idx_nxt;
    best_pri_r   <= best_pri_nxt;
    best_arr_r   <= best_arr_nxt;
    best_burst_r <= best_burst_nxt;
    next_arr_r   <= next_arr_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT) begin
      pnum_r     <= nps_pkg::PNUM_W'(idx_r) + 1'b1;
      start_t_r  <= ent.run_start;
      finish_t_r <= ent.finish_time;
      wait_t_r   <= wait_calc;
      turn_t_r   <= turn_calc;
      owsum_r    <= wsum_r + nps_pkg::SUM_W'(wait_calc);
      otsum_r    <= tsum_r + nps_pkg::SUM_W'(turn_calc);
      olast_r    <= idx_at_end;
    end
  end

  assign out_strobe           = strobe_r;
  assign out_process_number   = pnum_r;
  assign out_start_time       = start_t_r;
  assign out_finish_time      = finish_t_r;
  assign out_wait_time        = wait_t_r;
  assign out_turnaround       = turn_t_r;
  assign out_total_wait       = owsum_r;
  assign out_total_turnaround = otsum_r;
  assign out_last_result      = olast_r;

  // checks
  `NPS_ASSERT_IMPL(a_strobe_after_emit, clk, rst_n, strobe_r, $past(state_r) == ST_EMIT)
  `NPS_ASSERT_IMPL(a_last_clears_table, clk, rst_n, strobe_r && olast_r, count_r == '0 && !busy)
  `NPS_ASSERT_NEVER(a_decide_without_work, clk, rst_n, state_r == ST_DECIDE && !have_r && !any_r)
endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Testbench for nonpreemptive_priority_scheduler_top: sends process record sets
// and checks every per-process result against an in-bench schedule predictor.
// Depends on nps_pkg and the scheduler top level.
module tb;
  import nps_pkg::*;

  localparam int STALL_LIMIT   = 4000;  // cycles with no transfer at all
  localparam int TARGET_RECS   = 420;
  localparam int SETTLE_CYCLES = 40;

  // Spread of generated arrival and burst values
  typedef enum int {SPREAD_TIGHT, SPREAD_NEAR, SPREAD_WIDE} spread_e;
  // Mix of generated priority values within one set
  typedef enum int {PRIO_FEW, PRIO_SAME, PRIO_ANY} prio_mix_e;

  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRI_W-1:0]   prio;
    logic               last;
  } proc_rec_t;

  typedef struct packed {
    logic [PNUM_W-1:0] pnum;
    logic [TIME_W-1:0] start_t;
    logic [TIME_W-1:0] finish_t;
    logic [TIME_W-1:0] wait_t;
    logic [TIME_W-1:0] turn_t;
    logic [SUM_W-1:0]  sum_wait;
    logic [SUM_W-1:0]  sum_turn;
    logic              last;
  } proc_result_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [ARR_W-1:0]    in_arrival_time;
  logic [BURST_W-1:0]  in_burst_time;
  logic [PRI_W-1:0]    in_priority_level;
  logic                in_last_process;
  logic                out_strobe;
  logic [PNUM_W-1:0]   out_process_number;
  logic [TIME_W-1:0]   out_start_time;
  logic [TIME_W-1:0]   out_finish_time;
  logic [TIME_W-1:0]   out_wait_time;
  logic [TIME_W-1:0]   out_turnaround;
  logic [SUM_W-1:0]    out_total_wait;
  logic [SUM_W-1:0]    out_total_turnaround;
  logic                out_last_result;

  // Predictor copy of the process table
  logic [ARR_W-1:0]    arr_tab   [MAX_PROCS];
  logic [BURST_W-1:0]  burst_tab [MAX_PROCS];
  logic [PRI_W-1:0]    prio_tab  [MAX_PROCS];
  int unsigned         stored_cnt = 0;

  proc_result_t        due_results [$];
  int unsigned         error_cnt    = 0;
  int unsigned         sets_run     = 0;
  int unsigned         recs_sent    = 0;
  int unsigned         results_seen = 0;
  int unsigned         burst_left   = 0;
  int unsigned         stall_cnt    = 0;

  nonpreemptive_priority_scheduler_top u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_arrival_time      (in_arrival_time),
    .in_burst_time        (in_burst_time),
    .in_priority_level    (in_priority_level),
    .in_last_process      (in_last_process),
    .out_strobe           (out_strobe),
    .out_process_number   (out_process_number),
    .out_start_time       (out_start_time),
    .out_finish_time      (out_finish_time),
    .out_wait_time        (out_wait_time),
    .out_turnaround       (out_turnaround),
    .out_total_wait       (out_total_wait),
    .out_total_turnaround (out_total_turnaround),
    .out_last_result      (out_last_result)
  );

  // 10-unit clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run the stored set through non-preemptive priority scheduling and queue
  // one result per process in number order; the table then empties.
  function automatic void compute_schedule();
    logic [TIME_W-1:0] now_t;
    logic [TIME_W-1:0] start_at [MAX_PROCS];
    logic [TIME_W-1:0] end_at   [MAX_PROCS];
    bit                ran      [MAX_PROCS];
    int unsigned       served;
    int                pick;
    logic [ARR_W-1:0]  soonest;
    logic [TIME_W-1:0] turn_t;
    logic [SUM_W-1:0]  wait_acc;
    logic [SUM_W-1:0]  turn_acc;
    proc_result_t      res;
    now_t    = '0;
    served   = 0;
    wait_acc = '0;
    turn_acc = '0;
    foreach (ran[i]) ran[i] = 1'b0;
    while (served < stored_cnt) begin
      // lowest priority value among ready ones; ties to earlier arrival,
      // then lower number (the scan is ascending, so the first one stays)
      pick = -1;
      for (int i = 0; i < stored_cnt; i++) begin
        if (ran[i] || arr_tab[i] > now_t) continue;
        if (pick < 0 || prio_tab[i] < prio_tab[pick] ||
            (prio_tab[i] == prio_tab[pick] && arr_tab[i] < arr_tab[pick]))
          pick = i;
      end
      if (pick < 0) begin
        // nothing ready: jump to the earliest unfinished arrival
        soonest = '1;
        for (int i = 0; i < stored_cnt; i++)
          if (!ran[i] && arr_tab[i] < soonest) soonest = arr_tab[i];
        now_t = TIME_W'(soonest);
      end else begin
        start_at[pick] = now_t;
        now_t = now_t + TIME_W'(burst_tab[pick]);
        end_at[pick] = now_t;
        ran[pick] = 1'b1;
        served++;
      end
    end
    for (int k = 0; k < stored_cnt; k++) begin
      turn_t       = end_at[k] - TIME_W'(arr_tab[k]);
      res.pnum     = PNUM_W'(k + 1);
      res.start_t  = start_at[k];
      res.finish_t = end_at[k];
      res.turn_t   = turn_t;
      res.wait_t   = turn_t - TIME_W'(burst_tab[k]);
      wait_acc     = wait_acc + SUM_W'(res.wait_t);
      turn_acc     = turn_acc + SUM_W'(turn_t);
      res.sum_wait = wait_acc;
      res.sum_turn = turn_acc;
      res.last     = (k + 1 == stored_cnt);
      due_results.push_back(res);
    end
    stored_cnt = 0;
  endfunction

  // Update the predictor for one accepted record
  function automatic void record_transfer(input proc_rec_t r);
    if (stored_cnt < MAX_PROCS) begin
      arr_tab[stored_cnt]   = r.arrival;
      burst_tab[stored_cnt] = r.burst;
      prio_tab[stored_cnt]  = r.prio;
      stored_cnt++;
    end
    recs_sent++;
    if (r.last) begin
      compute_schedule();
      sets_run++;
    end
  endfunction

  function automatic proc_rec_t mk_rec(input int unsigned a, input int unsigned b,
                                       input int unsigned p, input bit l);
    proc_rec_t r;
    r.arrival = ARR_W'(a);
    r.burst   = BURST_W'(b);
    r.prio    = PRI_W'(p);
    r.last    = l;
    return r;
  endfunction

  function automatic proc_rec_t rand_rec(input spread_e arr_mode, input spread_e bur_mode,
                                         input prio_mix_e pri_mode,
                                         input logic [PRI_W-1:0] pri_same, input bit l);
    proc_rec_t r;
    case (arr_mode)
      SPREAD_TIGHT: r.arrival = ARR_W'($urandom_range(0, 3));
      SPREAD_NEAR:  r.arrival = ARR_W'($urandom_range(0, 60));
      default:      r.arrival = ARR_W'($urandom);
    endcase
    case (bur_mode)
      SPREAD_TIGHT: r.burst = BURST_W'($urandom_range(0, 3));
      SPREAD_NEAR:  r.burst = BURST_W'($urandom_range(1, 40));
      default:      r.burst = BURST_W'($urandom);
    endcase
    case (pri_mode)
      PRIO_FEW:  r.prio = PRI_W'($urandom_range(0, 2));
      PRIO_SAME: r.prio = pri_same;
      default:   r.prio = PRI_W'($urandom);
    endcase
    r.last = l;
    return r;
  endfunction

  // Drive one record until it transfers, then either keep start high for the
  // next one or drop it for a random gap when the burst runs out.
  task automatic send_record(input proc_rec_t r);
    in_arrival_time   <= r.arrival;
    in_burst_time     <= r.burst;
    in_priority_level <= r.prio;
    in_last_process   <= r.last;
    start             <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    record_transfer(r);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 5);
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Stop sending and let every queued result come out
  task automatic drain();
    if (start) start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One-record sets at both ends of every field
  task automatic test_single_record();
    send_record(mk_rec(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1));
    send_record(mk_rec(0, 0, 0, 1'b1));
    drain();
  endtask

  // Priority ties, arrival ties, zero burst and an idle stretch
  task automatic test_ties_and_gaps();
    send_record(mk_rec(10, 5, 3, 1'b0));
    send_record(mk_rec(10, 7, 3, 1'b0));
    send_record(mk_rec(4, 2, 3, 1'b0));
    send_record(mk_rec(0, 0, 0, 1'b0));
    send_record(mk_rec(100, 20, 1, 1'b0));
    send_record(mk_rec(200, 1, 0, 1'b1));
    drain();
  endtask

  // Full table: the 17th record is dropped but its last mark starts the run
  task automatic test_store_full();
    for (int i = 0; i <= MAX_PROCS; i++)
      send_record(rand_rec(SPREAD_NEAR, SPREAD_NEAR, PRIO_FEW, '0, i == MAX_PROCS));
    drain();
  endtask

  // Random sets, mostly small, back to back with results still streaming
  task automatic test_random_sets();
    int unsigned      set_len;
    spread_e          arr_mode;
    spread_e          bur_mode;
    prio_mix_e        pri_mode;
    logic [PRI_W-1:0] pri_same;
    while (recs_sent < TARGET_RECS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: set_len = $urandom_range(1, 4);
        6, 7:             set_len = $urandom_range(5, 10);
        8:                set_len = $urandom_range(11, MAX_PROCS);
        default:          set_len = $urandom_range(MAX_PROCS, MAX_PROCS + 4);
      endcase
      arr_mode = spread_e'($urandom_range(0, 2));
      bur_mode = spread_e'($urandom_range(0, 2));
      pri_mode = prio_mix_e'($urandom_range(0, 2));
      pri_same = PRI_W'($urandom);
      for (int i = 0; i < set_len; i++)
        send_record(rand_rec(arr_mode, bur_mode, pri_mode, pri_same, i == set_len - 1));
    end
    drain();
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      error_cnt++;
    end
  endfunction

  // Compare each result transfer with the oldest predicted one
  always @(posedge clk) begin : result_check
    proc_result_t want;
    if (rst_n && out_strobe === 1'b1) begin
      results_seen++;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, process_number %0d", $time, out_process_number);
        error_cnt++;
      end else begin
        want = due_results.pop_front();
        check_field("process_number", want.pnum, out_process_number);
        check_field("start_time", want.start_t, out_start_time);
        check_field("finish_time", want.finish_t, out_finish_time);
        check_field("wait_time", want.wait_t, out_wait_time);
        check_field("turnaround", want.turn_t, out_turnaround);
        check_field("total_wait", want.sum_wait, out_total_wait);
        check_field("total_turnaround", want.sum_turn, out_total_turnaround);
        check_field("last_result", want.last, out_last_result);
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe === 1'b1) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_arrival_time   <= '0;
    in_burst_time     <= '0;
    in_priority_level <= '0;
    in_last_process   <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_single_record();
    test_ties_and_gaps();
    test_store_full();
    test_random_sets();
    $display("Covered %0d record sets built from %0d records, %0d results compared.",
             sets_run, recs_sent, results_seen);
    if (error_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
